### sv/assert_macros.svh
// Assertion macros included by the allocator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### sv/ipa_pkg.sv
// Package of the id pool allocator: codes and fixed widths
package ipa_pkg;
   localparam int ID_W   = 32;
   localparam int SIZE_W = 11;
   localparam int PCT_W  = 7;
   localparam int MODE_W = 3;
   localparam int NUM_W  = 18;

   localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RESERVE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

   localparam logic CSR_BASE_ID   = 1'b0;
   localparam logic CSR_POOL_SIZE = 1'b1;
endpackage

### sv/ipa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
module ipa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

### sv/id_pool_allocator.sv
// Top level of the id pool allocator: free list and marks in RAM, sequencer
// One command at a time. Allocate, release, query and other modes raise the
// result strobe after a RAM read state, a divider setup state and a bit-serial
// divider for the usage percent. busy drops with the strobe, so the next
// command can be taken at the edge that ends it. Reserve also walks the free
// list, one entry per walk step, until the named id is found or the list ends.
// Reset, a register write and clear run a pass over all POOL_DEPTH list
// entries, one a cycle, with busy high; a register write is taken at any edge
// and restarts that pass. The result strobe lasts one cycle and cannot be held.
module id_pool_allocator
   import ipa_pkg::*;
#(
   parameter int POOL_DEPTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [ID_W-1:0]   req_id,
   output logic              rsp_strobe,
   output logic [ID_W-1:0]   rsp_result_id,
   output logic              rsp_success,
   output logic              rsp_in_range,
   output logic              rsp_was_allocated,
   output logic [SIZE_W-1:0] rsp_allocated_count,
   output logic [PCT_W-1:0]  rsp_load_pct,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [ID_W-1:0]   csr_wdata
);
   localparam int IW = $clog2(POOL_DEPTH);
   localparam int LW = IW + 1;
   localparam logic [LW-1:0] NIL = LW'(POOL_DEPTH);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_WALK, ST_DSET, ST_DIV
   } state_type;

   state_type         state_ff;
   logic [ID_W-1:0]   base_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [SIZE_W-1:0] eff_ff;
   logic [SIZE_W-1:0] eff_in;
   logic [LW-1:0]     head_ff;
   logic [SIZE_W-1:0] count_ff;
   logic [IW-1:0]     clr_ff;
   logic              pend_ff;
   logic [MODE_W-1:0] mode_ff;
   logic [ID_W-1:0]   id_ff;
   logic              inr_ff;
   logic [IW-1:0]     idx_ff;
   logic [LW-1:0]     prev_ff;
   logic [LW-1:0]     cur_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [NUM_W-1:0]  dvs_ff;
   logic [2:0]        k_ff;
   logic [PCT_W-1:0]  q_ff;
   logic [PCT_W-1:0]  q_in;
   logic              rsp_strobe_ff;

   // request decode
   logic [ID_W-1:0] off;
   logic            inr;
   logic            was;
   assign off = req_id - base_ff;
   assign inr = (eff_ff != '0) && (req_id >= base_ff) && (off < ID_W'(eff_ff));

   // effective size: limited by depth and by room to the top of the id space
   logic [ID_W:0] room;
   logic [SIZE_W-1:0] cap;
   assign room = {1'b1, {ID_W{1'b0}}} - {1'b0, base_ff};
   assign cap  = (32'(size_ff) > 32'(POOL_DEPTH)) ? SIZE_W'(POOL_DEPTH) : size_ff;
   assign eff_in = ((ID_W+1)'(cap) > room) ? SIZE_W'(room) : cap;

   // memories
   logic            mark_we, mark_wd, mark_q;
   logic [IW-1:0]   mark_waddr;
   logic            nxt_we;
   logic [IW-1:0]   nxt_waddr, nxt_raddr;
   logic [LW-1:0]   nxt_wd, nxt_q;
   logic [IW:0]     clr_next;

   assign was      = inr_ff && mark_q;
   assign clr_next = {1'b0, clr_ff} + 1'b1;

   ipa_ram #(.WIDTH(1), .DEPTH(POOL_DEPTH)) u_marks (
      .clock(clock), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wd),
      .raddr(off[IW-1:0]), .rdata(mark_q)
   );

   ipa_ram #(.WIDTH(LW), .DEPTH(POOL_DEPTH)) u_next (
      .clock(clock), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wd),
      .raddr(nxt_raddr), .rdata(nxt_q)
   );

   // memory write and read control
   always_comb begin
      mark_we    = 1'b0;
      mark_wd    = 1'b0;
      mark_waddr = idx_ff;
      nxt_we     = 1'b0;
      nxt_waddr  = idx_ff;
      nxt_wd     = head_ff;
      nxt_raddr  = nxt_q[IW-1:0];
      case (state_ff)
         ST_CLEAR: begin
            mark_we    = 1'b1;
            mark_waddr = clr_ff;
            nxt_we     = 1'b1;
            nxt_waddr  = clr_ff;
            nxt_wd     = (32'(clr_next) < 32'(eff_in)) ? LW'(clr_next) : NIL;
         end
         ST_IDLE: begin
            nxt_raddr = head_ff[IW-1:0];
         end
         ST_READ: begin
            case (mode_ff)
               MODE_ALLOC: begin
                  mark_we    = (head_ff != NIL);
                  mark_wd    = 1'b1;
                  mark_waddr = head_ff[IW-1:0];
               end
               MODE_RELEASE: begin
                  mark_we = was;
                  nxt_we  = was;
               end
               MODE_RESERVE: begin
                  mark_we = inr_ff && !was && (head_ff == {1'b0, idx_ff});
                  mark_wd = 1'b1;
               end
               default: begin
               end
            endcase
         end
         ST_WALK: begin
            if (cur_ff != NIL && cur_ff == {1'b0, idx_ff}) begin
               mark_we   = 1'b1;
               mark_wd   = 1'b1;
               nxt_we    = 1'b1;
               nxt_waddr = prev_ff[IW-1:0];
               nxt_wd    = nxt_q;
            end
         end
         default: begin
         end
      endcase
   end

   // divider step
   logic             dge;
   assign dge  = num_ff >= dvs_ff;
   assign q_in = dge ? (q_ff | (PCT_W'(1) << k_ff)) : q_ff;

   // sequencer; a register write restarts the clearing pass from any state
   always_ff @(posedge clock) begin
      rsp_strobe_ff <= 1'b0;
      eff_ff        <= eff_in;
      if (reset) begin
         state_ff <= ST_CLEAR;
         base_ff  <= '0;
         size_ff  <= SIZE_W'(1024);
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
         count_ff <= '0;
         head_ff  <= NIL;
      end else if (csr_we) begin
         if (csr_index == CSR_BASE_ID) begin
            base_ff <= csr_wdata;
         end else begin
            size_ff <= csr_wdata[SIZE_W-1:0];
         end
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
         state_ff <= ST_CLEAR;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == IW'(POOL_DEPTH - 1)) begin
                  head_ff  <= (eff_in != '0) ? '0 : NIL;
                  count_ff <= '0;
                  state_ff <= pend_ff ? ST_DSET : ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  mode_ff  <= req_mode;
                  id_ff    <= req_id;
                  inr_ff   <= inr;
                  idx_ff   <= off[IW-1:0];
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               rsp_result_id     <= id_ff;
               rsp_success       <= 1'b0;
               rsp_in_range      <= inr_ff;
               rsp_was_allocated <= was;
               state_ff          <= ST_DSET;
               case (mode_ff)
                  MODE_ALLOC: begin
                     rsp_was_allocated <= 1'b0;
                     if (head_ff != NIL) begin
                        head_ff       <= nxt_q;
                        count_ff      <= count_ff + 1'b1;
                        rsp_result_id <= base_ff + ID_W'(head_ff);
                        rsp_success   <= 1'b1;
                        rsp_in_range  <= 1'b1;
                     end else begin
                        rsp_result_id <= '1;
                        rsp_in_range  <= 1'b0;
                     end
                  end
                  MODE_RELEASE: begin
                     if (was) begin
                        head_ff     <= {1'b0, idx_ff};
                        count_ff    <= count_ff - 1'b1;
                        rsp_success <= 1'b1;
                     end
                  end
                  MODE_RESERVE: begin
                     if (inr_ff && !was) begin
                        if (head_ff == {1'b0, idx_ff}) begin
                           head_ff     <= nxt_q;
                           count_ff    <= count_ff + 1'b1;
                           rsp_success <= 1'b1;
                        end else if (head_ff != NIL) begin
                           prev_ff  <= head_ff;
                           cur_ff   <= nxt_q;
                           state_ff <= ST_WALK;
                        end
                     end
                  end
                  MODE_QUERY: begin
                     rsp_success <= was;
                  end
                  MODE_CLEAR: begin
                     clr_ff   <= '0;
                     pend_ff  <= 1'b1;
                     state_ff <= ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
            ST_WALK: begin
               if (cur_ff == NIL) begin
                  state_ff <= ST_DSET;
               end else if (cur_ff == {1'b0, idx_ff}) begin
                  count_ff    <= count_ff + 1'b1;
                  rsp_success <= 1'b1;
                  state_ff    <= ST_DSET;
               end else begin
                  prev_ff <= cur_ff;
                  cur_ff  <= nxt_q;
               end
            end
            ST_DSET: begin
               num_ff   <= NUM_W'(count_ff) * NUM_W'(100);
               dvs_ff   <= NUM_W'({eff_ff, 6'b0});
               k_ff     <= 3'd6;
               q_ff     <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (dge) begin
                  num_ff <= num_ff - dvs_ff;
               end
               dvs_ff <= dvs_ff >> 1;
               q_ff   <= q_in;
               k_ff   <= k_ff - 1'b1;
               if (k_ff == '0) begin
                  rsp_allocated_count <= count_ff;
                  rsp_load_pct        <= (eff_ff == '0) ? '0 : q_in;
                  rsp_strobe_ff       <= 1'b1;
                  state_ff            <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;

`include "assert_macros.svh"

   `ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
   `ASSERT_SAME(a_count_le_size, clock, reset, state_ff == ST_IDLE, count_ff <= eff_ff)
   `ASSERT_SAME(a_pct_bound, clock, reset, rsp_strobe, rsp_load_pct <= PCT_W'(100))
   `ASSERT_NEXT(a_busy_after_start, clock, reset, start && !busy && !csr_we, busy)
endmodule

### tb/tb.sv
// Testbench of the id pool allocator: directed and random commands with a scoreboard
module tb
   import ipa_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH     = 1024;
   localparam int NIL       = DEPTH;
   localparam int IDLE_LIMIT = 20000;

   // one result word
   typedef struct {
      logic [ID_W-1:0]   result_id;
      logic              success;
      logic              in_range;
      logic              was_allocated;
      logic [SIZE_W-1:0] allocated_count;
      logic [PCT_W-1:0]  load_pct;
   } outcome_type;

   // Scoreboard: own copy of the pool, expected words in order
   class id_pool_scoreboard;
      bit [ID_W-1:0] base;
      int unsigned   size_reg;
      int unsigned   eff;
      bit            marks [DEPTH];
      int unsigned   nxt [DEPTH];
      int unsigned   head;
      int unsigned   count;
      outcome_type   expected_words [$];
      int            errors;

      function new();
         base = '0;
         size_reg = DEPTH;
         errors = 0;
         rebuild_pool();
      endfunction

      function void rebuild_pool();
         longint sz;
         longint room;
         sz = size_reg;
         room = 64'd4294967296 - longint'(base);
         if (sz > DEPTH) sz = DEPTH;
         if (sz > room) sz = room;
         eff = int'(sz);
         for (int i = 0; i < DEPTH; i++) begin
            marks[i] = 1'b0;
            nxt[i] = (i + 1 < eff) ? i + 1 : NIL;
         end
         head = (eff > 0) ? 0 : NIL;
         count = 0;
      endfunction

      function void write_reg(logic idx, logic [ID_W-1:0] value);
         if (idx == CSR_BASE_ID) base = value;
         else size_reg = value & 32'h7FF;
         rebuild_pool();
      endfunction

      // accepted command: update the pool and queue the expected word
      function void note(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id);
         outcome_type o;
         bit [ID_W-1:0] off;
         bit inr;
         bit was;
         int unsigned idx;
         int unsigned prev;
         int unsigned cur;
         off = id - base;
         inr = (eff != 0) && (id >= base) && (off < eff);
         idx = inr ? int'(off) : 0;
         was = inr && marks[idx];
         o.result_id = id;
         o.success = 1'b0;
         case (mode)
            MODE_ALLOC: begin
               inr = 0;
               was = 0;
               o.result_id = '1;
               if (head < NIL) begin
                  idx = head;
                  head = nxt[idx];
                  nxt[idx] = NIL;
                  marks[idx] = 1'b1;
                  count++;
                  o.result_id = base + idx;
                  inr = 1;
                  o.success = 1'b1;
               end
            end
            MODE_RELEASE: begin
               if (was) begin
                  marks[idx] = 1'b0;
                  count--;
                  nxt[idx] = head;
                  head = idx;
                  o.success = 1'b1;
               end
            end
            MODE_RESERVE: begin
               if (inr && !was) begin
                  prev = NIL;
                  cur = head;
                  for (int s = 0; s < DEPTH && cur < NIL; s++) begin
                     if (cur == idx) begin
                        if (prev < NIL) nxt[prev] = nxt[cur];
                        else head = nxt[cur];
                        nxt[cur] = NIL;
                        marks[idx] = 1'b1;
                        count++;
                        o.success = 1'b1;
                        break;
                     end
                     prev = cur;
                     cur = nxt[cur];
                  end
               end
            end
            MODE_QUERY: o.success = was;
            MODE_CLEAR: rebuild_pool();
            default: ;
         endcase
         o.in_range = inr;
         o.was_allocated = was;
         o.allocated_count = count[SIZE_W-1:0];
         o.load_pct = (eff == 0) ? '0 : PCT_W'((count * 100) / eff);
         expected_words.insert(expected_words.size(), o);
      endfunction

      function void report(string what, logic [ID_W-1:0] got, logic [ID_W-1:0] want);
         $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
         errors++;
      endfunction

      function void check(outcome_type g);
         outcome_type e;
         if (expected_words.size() == 0) begin
            report("unexpected word", g.result_id, '0);
            return;
         end
         e = expected_words.pop_front();
         if (g.result_id !== e.result_id) report("result_id", g.result_id, e.result_id);
         if (g.success !== e.success) report("success", g.success, e.success);
         if (g.in_range !== e.in_range) report("in_range", g.in_range, e.in_range);
         if (g.was_allocated !== e.was_allocated)
            report("was_allocated", g.was_allocated, e.was_allocated);
         if (g.allocated_count !== e.allocated_count)
            report("allocated_count", g.allocated_count, e.allocated_count);
         if (g.load_pct !== e.load_pct)
            report("load_pct", g.load_pct, e.load_pct);
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [MODE_W-1:0] req_mode;
   logic [ID_W-1:0]   req_id;
   logic              rsp_strobe;
   logic [ID_W-1:0]   rsp_result_id;
   logic              rsp_success;
   logic              rsp_in_range;
   logic              rsp_was_allocated;
   logic [SIZE_W-1:0] rsp_allocated_count;
   logic [PCT_W-1:0]  rsp_load_pct;
   logic              csr_we;
   logic              csr_index;
   logic [ID_W-1:0]   csr_wdata;

   id_pool_scoreboard pool_sb;
   int idle_cycles;

   id_pool_allocator i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // check every result word
   always @(posedge clock) begin
      outcome_type g;
      if (!reset && rsp_strobe) begin
         g.result_id = rsp_result_id;
         g.success = rsp_success;
         g.in_range = rsp_in_range;
         g.was_allocated = rsp_was_allocated;
         g.allocated_count = rsp_allocated_count;
         g.load_pct = rsp_load_pct;
         pool_sb.check(g);
      end
   end

   // watchdog: cycles with no command taken, no register written, no word returned
   always @(posedge clock) begin
      if (reset || (start && !busy) || csr_we || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("id_pool_allocator regression: fail");
         $finish;
      end
   end

   // hold the command until the block takes it
   task automatic issue(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id);
      start <= 1'b1;
      req_mode <= mode;
      req_id <= id;
      do @(posedge clock); while (busy);
      pool_sb.note(mode, id);
   endtask

   // random gap, mostly none or short
   task automatic idle_gap();
      int n;
      int r;
      r = $urandom_range(0, 99);
      n = (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // drain, then write both registers
   task automatic set_pool(logic [ID_W-1:0] base, logic [ID_W-1:0] size);
      start <= 1'b0;
      do @(posedge clock); while (pool_sb.expected_words.size() > 0 || busy);
      csr_we <= 1'b1;
      csr_index <= CSR_BASE_ID;
      csr_wdata <= base;
      @(posedge clock);
      pool_sb.write_reg(CSR_BASE_ID, base);
      csr_index <= CSR_POOL_SIZE;
      csr_wdata <= size;
      @(posedge clock);
      pool_sb.write_reg(CSR_POOL_SIZE, size);
      csr_we <= 1'b0;
   endtask

   function automatic logic [ID_W-1:0] pick_id();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return pool_sb.base + $urandom_range(0, pool_sb.eff);
      if (r < 85) return pool_sb.base - 1;
      return $urandom;
   endfunction

   task automatic random_words(int n);
      int r;
      logic [MODE_W-1:0] m;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 32) m = MODE_ALLOC;
         else if (r < 57) m = MODE_RELEASE;
         else if (r < 75) m = MODE_RESERVE;
         else if (r < 93) m = MODE_QUERY;
         else if (r < 96) m = MODE_CLEAR;
         else m = MODE_W'($urandom_range(5, 7));
         issue(m, pick_id());
         idle_gap();
      end
   endtask

   initial begin
      pool_sb = new();
      idle_cycles = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_mode <= MODE_ALLOC;
      req_id <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_BASE_ID;
      csr_wdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: default pool of 1024 at base 0
      issue(MODE_ALLOC, '0);
      issue(MODE_ALLOC, '1);
      issue(MODE_QUERY, 32'd0);
      issue(MODE_QUERY, 32'd1023);
      issue(MODE_QUERY, 32'd1024);
      issue(MODE_RELEASE, 32'd0);
      issue(MODE_RELEASE, 32'd0);
      issue(MODE_RESERVE, 32'd5);
      issue(MODE_RESERVE, 32'd5);
      issue(MODE_RESERVE, 32'd0);
      issue(MODE_RESERVE, 32'd1023);
      issue(MODE_RESERVE, 32'd1024);
      issue(MODE_QUERY, 32'hFFFF_FFFF);
      issue(3'd5, 32'd5);
      issue(3'd6, 32'hAAAA_AAAA);
      issue(3'd7, 32'h5555_5555);
      issue(MODE_CLEAR, 32'd5);
      issue(MODE_ALLOC, '0);
      random_words(60);

      // several pool settings, extremes among them
      set_pool(32'hFFFF_FFFC, 32'd16);  // clipped at the top of the id space
      random_words(80);
      set_pool(32'd100, 32'd0);         // empty pool
      issue(MODE_ALLOC, '0);
      issue(MODE_RESERVE, 32'd100);
      random_words(20);
      set_pool(32'hFFFF_FFFF, 32'd2047); // one id left
      random_words(60);
      set_pool($urandom, 32'd8);
      random_words(110);
      set_pool(32'd50, 32'd1);
      random_words(50);
      set_pool($urandom_range(0, 32'h7FFF_FFFF), 32'd2047);
      random_words(60);
      set_pool(32'd1000, 32'd3);
      random_words(100);

      start <= 1'b0;
      do @(posedge clock); while (pool_sb.expected_words.size() > 0);
      repeat (20) @(posedge clock);
      if (pool_sb.errors == 0 && pool_sb.expected_words.size() == 0) begin
         $display("id_pool_allocator regression: pass");
      end else begin
         $display("id_pool_allocator regression: fail");
      end
      $finish;
   end
endmodule
